/* hdl/ypp_pkg.sv */
// Shared constants and the arctangent table for the yaw/pitch pipeline.
// No dependencies; every other file refers to it by scoped names.
package ypp_pkg;

    // Angle accumulator width, degree * 2^16, signed
    localparam int ANGLE_W = 28;
    localparam int OFFSET_W = 17;
    localparam int YAW_W = 17;
    localparam int PITCH_W = 16;
    localparam int ROUND_W = ANGLE_W - 8;

    localparam logic signed [ANGLE_W-1:0] DEG90 = 28'sd5898240;
    localparam logic signed [ANGLE_W-1:0] DEG180 = 28'sd11796480;
    localparam logic signed [ANGLE_W-1:0] ROUND_HALF = 28'sd128;
    localparam logic signed [ROUND_W-1:0] YAW_MOD = 20'sd92160;
    localparam logic signed [ROUND_W-1:0] PITCH_LIMIT = 20'sd23040;
    localparam int GAIN_Q16 = 107922;
    localparam logic signed [OFFSET_W-1:0] HEIGHT_RESET = 17'sd128;

    // atan(2^-i) in degree * 2^16, rounded to nearest
    function automatic logic signed [ANGLE_W-1:0] atan_q16(input int idx);
        logic signed [ANGLE_W-1:0] v;
        v = '0;
        case (idx)
            0: v = 28'sd2949120;
            1: v = 28'sd1740967;
            2: v = 28'sd919879;
            3: v = 28'sd466945;
            4: v = 28'sd234379;
            5: v = 28'sd117304;
            6: v = 28'sd58666;
            7: v = 28'sd29335;
            8: v = 28'sd14668;
            9: v = 28'sd7334;
            10: v = 28'sd3667;
            11: v = 28'sd1833;
            12: v = 28'sd917;
            13: v = 28'sd458;
            14: v = 28'sd229;
            15: v = 28'sd115;
            16: v = 28'sd57;
            17: v = 28'sd29;
            18: v = 28'sd14;
            19: v = 28'sd7;
            20: v = 28'sd4;
            21: v = 28'sd2;
            22: v = 28'sd1;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

/* hdl/ypp_if.sv */
// Valid/ready channel interfaces for position items in and angle items out.
// Uses widths from ypp_pkg.
interface ypp_in_if #(parameter int POSITION_BITS = 24);
    logic valid;
    logic ready;
    logic signed [POSITION_BITS-1:0] player_x;
    logic signed [POSITION_BITS-1:0] player_y;
    logic signed [POSITION_BITS-1:0] player_z;
    logic signed [POSITION_BITS-1:0] target_x;
    logic signed [POSITION_BITS-1:0] target_y;
    logic signed [POSITION_BITS-1:0] target_z;
    modport source (output valid, player_x, player_y, player_z,
                    target_x, target_y, target_z, input ready);
    modport sink (input valid, player_x, player_y, player_z,
                  target_x, target_y, target_z, output ready);
endinterface

interface ypp_out_if;
    logic valid;
    logic ready;
    logic [ypp_pkg::YAW_W-1:0] yaw_angle;
    logic signed [ypp_pkg::PITCH_W-1:0] pitch_angle;
    logic degenerate;
    modport source (output valid, yaw_angle, pitch_angle, degenerate, input ready);
    modport sink (input valid, yaw_angle, pitch_angle, degenerate, output ready);
endinterface

/* hdl/yaw_pitch_from_positions_top.sv */
// Aim direction pipeline: two front stages, CORDIC_STAGES yaw stages,
// CORDIC_STAGES pitch stages and one output stage.
// One item per cycle sustained, set by one register per CORDIC iteration.
// A stall freezes the whole pipeline.
// Reset (synchronous, active low) clears all valid bits and sets
// the height offset register to 128; no clearing pass.
module yaw_pitch_from_positions_top #(
    parameter int CORDIC_STAGES = 16,
    parameter int POSITION_BITS = 24
) (
    input  logic i_clk,
    input  logic i_rst_n,
    ypp_in_if.sink i_in,
    ypp_out_if.source o_res,
    input  logic psel,
    input  logic penable,
    input  logic pwrite,
    input  logic [2:0] paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic pready
);
    localparam int W = POSITION_BITS + 22;
    localparam int AW = ypp_pkg::ANGLE_W;

    logic en;
    logic signed [ypp_pkg::OFFSET_W-1:0] r_height;
    logic f_v, f_dg;
    logic signed [W-1:0] f_x, f_y, f_dzs;
    logic signed [AW-1:0] f_z;
    logic c1_v, c2_v;
    logic signed [W-1:0] c1_x, c2_x;
    logic signed [AW-1:0] c1_z, c2_z;
    logic [W:0] c1_sb;
    logic [AW:0] c2_sb;

    // Register port
    assign pready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_height <= ypp_pkg::HEIGHT_RESET;
        end else if (psel && penable && pwrite && !paddr[2]) begin
            r_height <= pwdata[ypp_pkg::OFFSET_W-1:0];
        end
    end
    assign prdata = paddr[2] ? 32'd0 : 32'(r_height);

    // Whole pipeline advances unless the output item is held
    assign en = !o_res.valid || o_res.ready;
    assign i_in.ready = en;

    ypp_front #(.P(POSITION_BITS), .W(W)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(i_in.valid),
        .i_px(i_in.player_x), .i_py(i_in.player_y), .i_pz(i_in.player_z),
        .i_tx(i_in.target_x), .i_ty(i_in.target_y), .i_tz(i_in.target_z),
        .i_height(r_height), .o_valid(f_v), .o_x(f_x), .o_y(f_y), .o_z(f_z),
        .o_dzs(f_dzs), .o_degen(f_dg)
    );

    // Yaw chain carries the scaled vertical offset alongside
    ypp_cordic_chain #(.STAGES(CORDIC_STAGES), .W(W), .SB_W(W + 1)) u_yaw (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(f_v),
        .i_x(f_x), .i_y(f_y), .i_z(f_z), .i_sb({f_dg, f_dzs}),
        .o_valid(c1_v), .o_x(c1_x), .o_z(c1_z), .o_sb(c1_sb)
    );

    // Pitch chain on (horizontal magnitude, scaled dz)
    ypp_cordic_chain #(.STAGES(CORDIC_STAGES), .W(W), .SB_W(AW + 1)) u_pitch (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(c1_v),
        .i_x(c1_x), .i_y(c1_sb[W-1:0]), .i_z('0), .i_sb({c1_sb[W], c1_z}),
        .o_valid(c2_v), .o_x(c2_x), .o_z(c2_z), .o_sb(c2_sb)
    );

    ypp_final u_final (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(c2_v),
        .i_yaw_z(c2_sb[AW-1:0]), .i_pitch_z(c2_z), .i_degen(c2_sb[AW]),
        .o_valid(o_res.valid), .o_yaw(o_res.yaw_angle),
        .o_pitch(o_res.pitch_angle), .o_degen(o_res.degenerate)
    );

    // Checks
    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.degenerate |-> o_res.yaw_angle == '0 &&
        o_res.pitch_angle == '0)
        else $error("degenerate item with nonzero angles");
    a_yaw_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> o_res.yaw_angle < 17'd92160)
        else $error("yaw out of range");
    a_pitch_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> o_res.pitch_angle <= 16'sd23040 &&
        o_res.pitch_angle >= -16'sd23040)
        else $error("pitch out of range");
    a_pitch_mag_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        c2_v && !c2_sb[AW] |-> !c2_x[W-1])
        else $error("negative horizontal magnitude");
endmodule

/* hdl/ypp_front.sv */
// Front end: offsets, zero test, half-plane fold and vertical gain scaling.
// Two register stages; uses ypp_pkg.
module ypp_front #(
    parameter int P = 24,
    parameter int W = 46
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_en,
    input  logic i_valid,
    input  logic signed [P-1:0] i_px,
    input  logic signed [P-1:0] i_py,
    input  logic signed [P-1:0] i_pz,
    input  logic signed [P-1:0] i_tx,
    input  logic signed [P-1:0] i_ty,
    input  logic signed [P-1:0] i_tz,
    input  logic signed [ypp_pkg::OFFSET_W-1:0] i_height,
    output logic o_valid,
    output logic signed [W-1:0] o_x,
    output logic signed [W-1:0] o_y,
    output logic signed [ypp_pkg::ANGLE_W-1:0] o_z,
    output logic signed [W-1:0] o_dzs,
    output logic o_degen
);
    logic r_va, r_vb;
    logic signed [P:0] r_dx, r_dy;
    logic signed [P+1:0] r_dz;
    logic r_dga;
    logic signed [W-1:0] r_x, r_y, r_dzs;
    logic signed [ypp_pkg::ANGLE_W-1:0] r_z;
    logic r_dgb;
    logic signed [W-1:0] n_x, n_y, dz_w;

    // Stage A: differences
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
        end else if (i_en) begin
            r_va <= i_valid;
        end
    end
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dx <= (P+1)'(i_tx) - (P+1)'(i_px);
            r_dy <= (P+1)'(i_ty) - (P+1)'(i_py);
            r_dz <= (P+2)'(i_tz) - (P+2)'(i_pz) + (P+2)'(i_height);
            r_dga <= (i_tx == i_px) && (i_ty == i_py);
        end
    end

    // Stage B: scale by 2^16, fold left half-plane, scale dz by the gain
    always_comb begin
        n_x = W'(r_dx) <<< 16;
        n_y = W'(r_dy) <<< 16;
        dz_w = W'(r_dz);
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vb <= 1'b0;
        end else if (i_en) begin
            r_vb <= r_va;
        end
    end
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (r_dx < 0) begin
                r_x <= -n_x;
                r_y <= -n_y;
                r_z <= ypp_pkg::DEG180 + ypp_pkg::DEG90;
            end else begin
                r_x <= n_x;
                r_y <= n_y;
                r_z <= ypp_pkg::DEG90;
            end
            r_dzs <= dz_w * W'(ypp_pkg::GAIN_Q16);
            r_dgb <= r_dga;
        end
    end

    assign o_valid = r_vb;
    assign o_x = r_x;
    assign o_y = r_y;
    assign o_z = r_z;
    assign o_dzs = r_dzs;
    assign o_degen = r_dgb;
endmodule

/* hdl/ypp_cordic_chain.sv */
// Vectoring CORDIC, one register stage per iteration, with a sideband
// carried alongside. Uses ypp_pkg for the arctangent table.
module ypp_cordic_chain #(
    parameter int STAGES = 16,
    parameter int W = 46,
    parameter int SB_W = 1
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_en,
    input  logic i_valid,
    input  logic signed [W-1:0] i_x,
    input  logic signed [W-1:0] i_y,
    input  logic signed [ypp_pkg::ANGLE_W-1:0] i_z,
    input  logic [SB_W-1:0] i_sb,
    output logic o_valid,
    output logic signed [W-1:0] o_x,
    output logic signed [ypp_pkg::ANGLE_W-1:0] o_z,
    output logic [SB_W-1:0] o_sb
);
    logic r_v [0:STAGES];
    logic signed [W-1:0] r_x [0:STAGES];
    logic signed [W-1:0] r_y [0:STAGES];
    logic signed [ypp_pkg::ANGLE_W-1:0] r_z [0:STAGES];
    logic [SB_W-1:0] r_sb [0:STAGES];

    assign r_v[0] = i_valid;
    assign r_x[0] = i_x;
    assign r_y[0] = i_y;
    assign r_z[0] = i_z;
    assign r_sb[0] = i_sb;

    for (genvar g = 0; g < STAGES; g++) begin : g_stage
        logic signed [W-1:0] xs, ys;
        assign xs = r_x[g] >>> g;
        assign ys = r_y[g] >>> g;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[g+1] <= 1'b0;
            end else if (i_en) begin
                r_v[g+1] <= r_v[g];
            end
        end

        // Rotate toward y = 0
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (!r_y[g][W-1]) begin
                    r_x[g+1] <= r_x[g] + ys;
                    r_y[g+1] <= r_y[g] - xs;
                    r_z[g+1] <= r_z[g] + ypp_pkg::atan_q16(g);
                end else begin
                    r_x[g+1] <= r_x[g] - ys;
                    r_y[g+1] <= r_y[g] + xs;
                    r_z[g+1] <= r_z[g] - ypp_pkg::atan_q16(g);
                end
                r_sb[g+1] <= r_sb[g];
            end
        end
    end

    assign o_valid = r_v[STAGES];
    assign o_x = r_x[STAGES];
    assign o_z = r_z[STAGES];
    assign o_sb = r_sb[STAGES];
endmodule

/* hdl/ypp_final.sv */
// Output stage: rounding to 1/256 degree, yaw wrap, pitch clamp, zero angles for degenerate items.
// Holds the output register; uses ypp_pkg.
module ypp_final (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_en,
    input  logic i_valid,
    input  logic signed [ypp_pkg::ANGLE_W-1:0] i_yaw_z,
    input  logic signed [ypp_pkg::ANGLE_W-1:0] i_pitch_z,
    input  logic i_degen,
    output logic o_valid,
    output logic [ypp_pkg::YAW_W-1:0] o_yaw,
    output logic signed [ypp_pkg::PITCH_W-1:0] o_pitch,
    output logic o_degen
);
    localparam int RW = ypp_pkg::ROUND_W;
    logic signed [ypp_pkg::ANGLE_W-1:0] ya, pa;
    logic signed [RW-1:0] yr, pr, yw, pc;
    logic r_v, r_dg;
    logic [ypp_pkg::YAW_W-1:0] r_yaw;
    logic signed [ypp_pkg::PITCH_W-1:0] r_pitch;

    always_comb begin
        ya = i_yaw_z + ypp_pkg::ROUND_HALF;
        pa = i_pitch_z + ypp_pkg::ROUND_HALF;
        yr = ya[ypp_pkg::ANGLE_W-1:8];
        pr = pa[ypp_pkg::ANGLE_W-1:8];
        // wrap into one turn
        priority if (yr < 0) begin
            yw = yr + ypp_pkg::YAW_MOD;
        end else if (yr >= ypp_pkg::YAW_MOD) begin
            yw = yr - ypp_pkg::YAW_MOD;
        end else begin
            yw = yr;
        end
        priority if (pr > ypp_pkg::PITCH_LIMIT) begin
            pc = ypp_pkg::PITCH_LIMIT;
        end else if (pr < -ypp_pkg::PITCH_LIMIT) begin
            pc = -ypp_pkg::PITCH_LIMIT;
        end else begin
            pc = pr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (i_en) begin
            r_v <= i_valid;
        end
    end
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dg <= i_degen;
            r_yaw <= i_degen ? '0 : yw[ypp_pkg::YAW_W-1:0];
            r_pitch <= i_degen ? '0 : pc[ypp_pkg::PITCH_W-1:0];
        end
    end

    assign o_valid = r_v;
    assign o_yaw = r_yaw;
    assign o_pitch = r_pitch;
    assign o_degen = r_dg;
endmodule

/* bench/tb_top.sv */
// Self-checking bench for the yaw/pitch aim pipeline: directed table, unused register check, then random items.
// Depends on ypp_pkg, ypp_in_if, ypp_out_if and yaw_pitch_from_positions_top.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STAGES = 16;
    localparam int POS_W = 24;
    localparam int LATENCY = 2 * STAGES + 3;
    localparam int ADDR_HEIGHT = 0;
    localparam int ADDR_UNUSED = 4;
    localparam int RANDOM_ITEMS = 1200;

    typedef struct {
        logic signed [POS_W-1:0] px, py, pz, tx, ty, tz;
    } pos_t;

    typedef struct {
        logic [ypp_pkg::YAW_W-1:0] yaw;
        logic signed [ypp_pkg::PITCH_W-1:0] pitch;
        logic degen;
    } aim_t;

    typedef struct {
        pos_t pos;
        bit typed;
        aim_t want;
    } row_t;

    // atan(2^-i), degree * 2^16
    localparam longint ATAN_Q16 [16] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115
    };

    logic i_clk;
    logic i_rst_n;
    logic psel, penable, pwrite, pready;
    logic [2:0] paddr;
    logic [31:0] pwdata, prdata;

    ypp_in_if #(.POSITION_BITS(POS_W)) in_ch ();
    ypp_out_if res_ch ();

    yaw_pitch_from_positions_top #(
        .CORDIC_STAGES(STAGES),
        .POSITION_BITS(POS_W)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in(in_ch),
        .o_res(res_ch),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    // bench copy of the height register
    logic signed [ypp_pkg::OFFSET_W-1:0] height_shadow;
    aim_t aim_q[$];
    row_t sent_q[$];
    int mismatches;
    int idle_pct;
    int stall_pct;
    bit hold_req = 1'b0;
    bit hold_done = 1'b0;
    int hold_left = 0;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #2000000;
        $display("status: fail");
        $finish;
    end

    // one vectoring chain; returns angle, leaves magnitude in x
    function automatic longint vector_angle(inout longint x, input longint y);
        longint z, xs, ys;
        z = 0;
        for (int i = 0; i < STAGES; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x = x + ys;
                y = y - xs;
                z = z + ATAN_Q16[i];
            end else begin
                x = x - ys;
                y = y + xs;
                z = z - ATAN_Q16[i];
            end
        end
        return z;
    endfunction

    function automatic aim_t predict_aim(input pos_t p,
                                         input logic signed [ypp_pkg::OFFSET_W-1:0] hofs);
        aim_t r;
        longint dx, dy, dz, x, y, z0, yaw, pitch;
        dx = longint'(p.tx) - longint'(p.px);
        dy = longint'(p.ty) - longint'(p.py);
        dz = longint'(p.tz) - longint'(p.pz) + longint'(hofs);
        r.yaw = '0;
        r.pitch = '0;
        r.degen = 1'b1;
        if (dx == 0 && dy == 0) return r;
        x = dx * 65536;
        y = dy * 65536;
        z0 = 0;
        if (x < 0) begin
            x = -x;
            y = -y;
            z0 = 11796480;
        end
        yaw = z0 + vector_angle(x, y) + 5898240;
        yaw = ((yaw + 128) >>> 8) % 92160;
        if (yaw < 0) yaw = yaw + 92160;
        pitch = (vector_angle(x, dz * 107922) + 128) >>> 8;
        if (pitch > 23040) pitch = 23040;
        if (pitch < -23040) pitch = -23040;
        r.yaw = yaw[ypp_pkg::YAW_W-1:0];
        r.pitch = pitch[ypp_pkg::PITCH_W-1:0];
        r.degen = 1'b0;
        return r;
    endfunction

    function automatic logic signed [POS_W-1:0] rand_pos();
        return POS_W'($urandom);
    endfunction

    // random item: half near targets, some full range, axis and zero cases
    function automatic pos_t rand_item();
        pos_t p;
        int kind;
        kind = $urandom_range(99);
        p.px = rand_pos();
        p.py = rand_pos();
        p.pz = rand_pos();
        p.tx = rand_pos();
        p.ty = rand_pos();
        p.tz = rand_pos();
        if (kind < 50) begin
            p.px = $signed(POS_W'($urandom_range(8000000))) - 4000000;
            p.py = $signed(POS_W'($urandom_range(8000000))) - 4000000;
            p.pz = $signed(POS_W'($urandom_range(8000000))) - 4000000;
            p.tx = p.px + $signed(POS_W'($urandom_range(200000))) - 100000;
            p.ty = p.py + $signed(POS_W'($urandom_range(200000))) - 100000;
            p.tz = p.pz + $signed(POS_W'($urandom_range(200000))) - 100000;
        end else if (kind < 58) begin
            p.tx = p.px;
        end else if (kind < 66) begin
            p.ty = p.py;
        end else if (kind < 72) begin
            p.tx = p.px;
            p.ty = p.py;
        end else if (kind < 78) begin
            p.tz = p.pz;
        end
        return p;
    endfunction

    // config write: setup then access cycle
    task automatic reg_write(input int addr, input logic [31:0] data);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= 3'(addr);
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == ADDR_HEIGHT) height_shadow = data[ypp_pkg::OFFSET_W-1:0];
    endtask

    // called right after a rising edge; returns right after the accepting edge
    task automatic send_item(input row_t r);
        bit taken;
        while ($urandom_range(99) < idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.player_x <= r.pos.px;
        in_ch.player_y <= r.pos.py;
        in_ch.player_z <= r.pos.pz;
        in_ch.target_x <= r.pos.tx;
        in_ch.target_y <= r.pos.ty;
        in_ch.target_z <= r.pos.tz;
        sent_q.push_back(r);
        do begin
            @(negedge i_clk);
            taken = in_ch.valid && in_ch.ready;
            @(posedge i_clk);
        end while (!taken);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (aim_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY) @(posedge i_clk);
    endtask

    // receiver ready, with a single long hold-off on request
    always @(posedge i_clk) begin
        if (hold_req && !hold_done) begin
            hold_done <= 1'b1;
            hold_left <= 400;
            res_ch.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            res_ch.ready <= 1'b0;
        end else begin
            res_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // sample both channels mid-cycle, away from the driving edge
    always @(negedge i_clk) begin
        aim_t want;
        row_t r;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (aim_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result item yaw=%0d", res_ch.yaw_angle);
            end else begin
                want = aim_q.pop_front();
                if (res_ch.yaw_angle !== want.yaw || res_ch.pitch_angle !== want.pitch
                        || res_ch.degenerate !== want.degen) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: want yaw=%0d pitch=%0d degen=%0b got %0d %0d %0b",
                                 want.yaw, want.pitch, want.degen, res_ch.yaw_angle,
                                 res_ch.pitch_angle, res_ch.degenerate);
                end
            end
        end
        if (i_rst_n && in_ch.valid && in_ch.ready) begin
            r = sent_q.pop_front();
            aim_q.push_back(r.typed ? r.want : predict_aim(r.pos, height_shadow));
        end
    end

    function automatic row_t mk(input int px, py, pz, tx, ty, tz, input bit typed = 0,
                                input int yaw = 0, pitch = 0, degen = 0);
        row_t r;
        r.pos.px = POS_W'(px);
        r.pos.py = POS_W'(py);
        r.pos.pz = POS_W'(pz);
        r.pos.tx = POS_W'(tx);
        r.pos.ty = POS_W'(ty);
        r.pos.tz = POS_W'(tz);
        r.typed = typed;
        r.want.yaw = ypp_pkg::YAW_W'(yaw);
        r.want.pitch = ypp_pkg::PITCH_W'(pitch);
        r.want.degen = degen[0];
        return r;
    endfunction

    localparam int PMAX = 8388607;
    localparam int PMIN = -8388608;

    initial begin
        row_t table_rows[$];
        int idle_set[4];
        int stall_set[4];
        int ofs_set[6];
        int phase_items;
        row_t r;

        idle_set = '{0, 86, 0, 86};
        stall_set = '{0, 0, 86, 86};
        ofs_set = '{128, -65536, 65535, 0, -1, 300};
        mismatches = 0;
        idle_pct = 0;
        stall_pct = 0;
        height_shadow = 17'sd128;
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_ch.valid = 1'b0;
        in_ch.player_x = '0;
        in_ch.player_y = '0;
        in_ch.player_z = '0;
        in_ch.target_x = '0;
        in_ch.target_y = '0;
        in_ch.target_z = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: zero offsets, extremes, axis cases
        table_rows.push_back(mk(0, 0, 0, 0, 0, 0, 1, 0, 0, 1));
        table_rows.push_back(mk(PMAX, PMIN, PMAX, PMAX, PMIN, PMIN, 1, 0, 0, 1));
        table_rows.push_back(mk(PMIN, PMAX, 5, PMIN, PMAX, -7, 1, 0, 0, 1));
        table_rows.push_back(mk(0, 0, 0, 256, 0, 0));
        table_rows.push_back(mk(0, 0, 0, -256, 0, 0));
        table_rows.push_back(mk(0, 0, 0, 0, 256, 0));
        table_rows.push_back(mk(0, 0, 0, 0, -256, 0));
        table_rows.push_back(mk(0, 0, 0, 256, 256, 0));
        table_rows.push_back(mk(0, 0, 0, -256, -256, 256));
        table_rows.push_back(mk(PMIN, PMIN, PMIN, PMAX, PMAX, PMAX));
        table_rows.push_back(mk(PMAX, PMAX, PMAX, PMIN, PMIN, PMIN));
        table_rows.push_back(mk(PMIN, 0, PMAX, PMAX, 0, PMIN));
        table_rows.push_back(mk(0, PMIN, PMIN, 0, PMAX, PMAX));
        table_rows.push_back(mk(0, 0, 0, 1, 0, PMAX));
        table_rows.push_back(mk(0, 0, PMAX, -1, 0, PMIN));
        table_rows.push_back(mk(0, 0, 0, 1, -1, 0));
        table_rows.push_back(mk(-1, -1, -1, 0, 0, 0));
        table_rows.push_back(mk(100, 200, 300, 100, 201, 300));
        table_rows.push_back(mk(PMAX, PMAX, 0, PMAX - 1, PMAX, 0));
        foreach (table_rows[i]) send_item(table_rows[i]);
        drain();

        // an unused register index must leave the offset alone
        reg_write(ADDR_UNUSED, 32'h0001_5555);
        @(posedge i_clk);
        send_item(mk(0, 0, 0, 256, 0, 0));
        drain();

        // random phases across offsets and idle and stall mixes
        for (int ph = 0; ph < 6; ph++) begin
            reg_write(ADDR_HEIGHT, (ph == 5) ? $urandom : 32'(ofs_set[ph]));
            @(posedge i_clk);
            idle_pct = idle_set[ph % 4];
            stall_pct = stall_set[ph % 4];
            if (ph == 4) begin
                idle_pct = 8;
                stall_pct = 8;
            end
            if (ph == 0) hold_req = 1'b1;
            phase_items = RANDOM_ITEMS / 6;
            for (int n = 0; n < phase_items; n++) begin
                r.pos = rand_item();
                r.typed = 1'b0;
                send_item(r);
                // sender waits for the pipeline to empty once, mid-way through the second phase
                if (ph == 1 && n == phase_items / 2) begin
                    in_ch.valid <= 1'b0;
                    while (aim_q.size() != 0) @(posedge i_clk);
                end
            end
            drain();
        end

        if (mismatches == 0 && aim_q.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
